/* rtl/gtg_pkg.sv */
// Shared constants and types of the go-to-goal pose controller.
package gtg_pkg;
    localparam logic [1:0] OP_ODOM   = 2'd0;
    localparam logic [1:0] OP_GOAL   = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;
    localparam logic [1:0] OP_RESET  = 2'd3;

    localparam logic [1:0] ST_IDLE      = 2'd0;
    localparam logic [1:0] ST_PENDING   = 2'd1;
    localparam logic [1:0] ST_SUCCEEDED = 2'd2;
    localparam logic [1:0] ST_CANCELED  = 2'd3;

    localparam logic [2:0] CFG_TOL  = 3'd0;
    localparam logic [2:0] CFG_LING = 3'd1;
    localparam logic [2:0] CFG_LINL = 3'd2;
    localparam logic [2:0] CFG_ANGG = 3'd3;
    localparam logic [2:0] CFG_ANGL = 3'd4;

    localparam logic signed [35:0] PI_Q30    = 36'sd3373259426;
    localparam logic [29:0]        INV_K_Q30 = 30'd652032874;
    localparam logic signed [17:0] PI_Q13    = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;

    // Arctangent of 2^-i in Q30.
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'd843314857;  5'd1: r = 32'd497837829;
                5'd2: r = 32'd263043837;  5'd3: r = 32'd133525159;
                5'd4: r = 32'd67021688;   5'd5: r = 32'd33543516;
                5'd6: r = 32'd16775851;   5'd7: r = 32'd8388437;
                5'd8: r = 32'd4194283;    5'd9: r = 32'd2097149;
                5'd31: r = 32'd0;
                default: r = 32'd1 << (5'd30 - i);
            endcase
            return r;
        end
    endfunction

    typedef struct packed {
        logic start;
        logic signed [35:0] x;
        logic signed [35:0] y;
    } gtg_cordic_req_t;

    typedef struct packed {
        logic done;
        logic signed [17:0] angle;
        logic [33:0] mag;
    } gtg_cordic_rsp_t;
endpackage

/* rtl/gtg_cordic.sv */
// Iterative CORDIC vectoring unit: one rotation step per cycle.
module gtg_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  gtg_pkg::gtg_cordic_req_t req,
    output gtg_pkg::gtg_cordic_rsp_t rsp
);
    import gtg_pkg::*;

    localparam int SW = $clog2(CORDIC_STEPS + 1);

    logic signed [37:0] x_reg, y_reg;
    logic signed [36:0] z_reg;
    logic [SW-1:0]      i_reg;
    logic               busy_reg, fin_reg, zero_reg;
    logic [1:0]         post_reg;
    logic [63:0]        prod_reg;

    logic signed [37:0] sx, sy;
    logic signed [36:0] zr;
    logic signed [18:0] q13;

    assign sx = x_reg >>> i_reg;
    assign sy = y_reg >>> i_reg;
    // Angle rounding to Q2.13 with clamp to +-pi.
    assign zr  = z_reg + 37'sd65536;
    assign q13 = 19'(zr >>> 17);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            post_reg <= 2'd0;
        end else begin
            // Done pulses for one cycle, right after the gain correction.
            fin_reg <= !req.start && !busy_reg && (post_reg == 2'd1);
            if (req.start) begin
                zero_reg <= (req.x == 36'sd0) && (req.y == 36'sd0);
                i_reg    <= '0;
                busy_reg <= 1'b1;
                if (req.x < 0) begin
                    x_reg <= -38'(req.x);
                    y_reg <= -38'(req.y);
                    z_reg <= (req.y >= 0) ? 37'(PI_Q30) : -37'(PI_Q30);
                end else begin
                    x_reg <= 38'(req.x);
                    y_reg <= 38'(req.y);
                    z_reg <= '0;
                end
            end else if (busy_reg) begin
                if (32'(i_reg) < CORDIC_STEPS && 32'(i_reg) < 32) begin
                    if (y_reg >= 0) begin
                        x_reg <= x_reg + sy;
                        y_reg <= y_reg - sx;
                        z_reg <= z_reg + 37'(atan_q30(5'(i_reg)));
                    end else begin
                        x_reg <= x_reg - sy;
                        y_reg <= y_reg + sx;
                        z_reg <= z_reg - 37'(atan_q30(5'(i_reg)));
                    end
                    i_reg <= i_reg + 1'b1;
                end else begin
                    busy_reg <= 1'b0;
                    post_reg <= 2'd1;
                end
            end else if (post_reg == 2'd1) begin
                // Magnitude gain correction, one multiply then register.
                prod_reg <= (x_reg < 0) ? 64'd0 :
                    64'(x_reg[33:0]) * 64'(INV_K_Q30) + 64'd536870912;
                post_reg <= 2'd0;
            end
        end
    end

    always_comb begin
        rsp.done = fin_reg;
        if (zero_reg) begin
            rsp.angle = '0;
            rsp.mag   = '0;
        end else begin
            rsp.mag = 34'(prod_reg >> 30);
            if (q13 > 19'(PI_Q13))       rsp.angle = PI_Q13;
            else if (q13 < -19'(PI_Q13)) rsp.angle = -PI_Q13;
            else                         rsp.angle = 18'(q13);
        end
    end
endmodule

/* rtl/go_to_goal_pose_controller_unit.sv */
// Top level of the go-to-goal pose controller.
// One input beat carries an operation (odometry, send goal, cancel or reset) with
// a position and an orientation quaternion, and each input beat yields exactly one
// result beat. Goal, cancel and reset beats go straight to S_OUT. An odometry beat
// while a goal is pending runs the shared CORDIC unit twice, once for the heading
// from the quaternion and once for distance and bearing to the goal, and then walks
// through S_MUL, S_FIN and S_OUT to a valid result; the heading pass is skipped (gimbal
// lock or a zero quaternion) when S_YAW does not start the CORDIC unit. The block takes
// no new beat until the result beat of the previous one has left the output register.
// Configuration writes take effect at once and should only be made while the block is
// idle.
module go_to_goal_pose_controller_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: pos_x[31:0], pos_y[63:32], quat_x, quat_y, quat_z, quat_w[127:112]
    input  logic [127:0] s_tdata,
    // tuser: operation[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: cmd_valid[0], linear_vel[31:1], angular_vel[63:32], goal_accepted[64],
    // goal_reached[65], nav_status[67:66], zero fill to 72 bits
    output logic [71:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [30:0]  cfg_data
);
    import gtg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_YAW = 3'd1, S_YAWW = 3'd2,
                           S_DIST = 3'd3, S_DISTW = 3'd4, S_MUL = 3'd5,
                           S_FIN = 3'd6, S_OUT = 3'd7;

    logic [30:0] tol_reg, linl_reg, angl_reg;
    logic [15:0] ling_reg, angg_reg;
    logic [31:0] gx_reg, gy_reg;
    logic        present_reg;
    logic [1:0]  status_reg;
    logic [2:0]  state_reg;

    logic signed [31:0] px_reg, py_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [17:0] yaw_reg;
    logic [71:0]        out_reg;
    logic [33:0]        dist_reg;
    logic signed [17:0] err_reg;
    logic [50:0]        lprod_reg;
    logic signed [35:0] aprod_reg;

    gtg_cordic_req_t creq;
    gtg_cordic_rsp_t crsp;

    gtg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .req(creq), .rsp(crsp)
    );

    // Quaternion terms; each product is one narrow multiply.
    logic signed [35:0] d2, tt, num, den;
    assign d2  = 36'(qx_reg * qx_reg) + 36'(qy_reg * qy_reg)
               + 36'(qz_reg * qz_reg) + 36'(qw_reg * qw_reg);
    assign tt  = 36'(qx_reg * qz_reg) - 36'(qw_reg * qy_reg);
    assign num = 2 * (36'(qx_reg * qy_reg) + 36'(qw_reg * qz_reg));
    assign den = 36'(qw_reg * qw_reg) + 36'(qx_reg * qx_reg)
               - 36'(qy_reg * qy_reg) - 36'(qz_reg * qz_reg);

    logic signed [32:0] dxw, dyw;
    logic signed [35:0] dxs, dys;
    assign dxw = 33'(signed'(gx_reg)) - 33'(px_reg);
    assign dyw = 33'(signed'(gy_reg)) - 33'(py_reg);
    always_comb begin
        dxs = (dxw > 33'sh0_7FFF_FFFF) ? 36'sh7FFF_FFFF :
              (dxw < -33'sh0_8000_0000) ? -36'sh8000_0000 : 36'(dxw);
        dys = (dyw > 33'sh0_7FFF_FFFF) ? 36'sh7FFF_FFFF :
              (dyw < -33'sh0_8000_0000) ? -36'sh8000_0000 : 36'(dyw);
    end

    logic signed [18:0] e0;
    logic signed [17:0] ew;
    assign e0 = 19'(crsp.angle) - 19'(yaw_reg);
    always_comb begin
        if (e0 > 19'(PI_Q13))       ew = 18'(e0 - 19'(TWO_PI_Q13));
        else if (e0 < -19'(PI_Q13)) ew = 18'(e0 + 19'(TWO_PI_Q13));
        else                        ew = 18'(e0);
    end

    // The turn rate limit as a signed value, so the clamp compares signed.
    logic signed [35:0] angl_s;
    assign angl_s = 36'(angl_reg);

    logic [50:0]        l_sh;
    logic signed [35:0] a_sh;
    logic [30:0]        lin_c;
    logic signed [31:0] ang_c;
    assign l_sh = lprod_reg >> 8;
    assign a_sh = aprod_reg >>> 5;
    always_comb begin
        lin_c = (l_sh > 51'(linl_reg)) ? linl_reg : 31'(l_sh);
        if (a_sh > angl_s)       ang_c = 32'(angl_reg);
        else if (a_sh < -angl_s) ang_c = -32'(angl_reg);
        else                     ang_c = 32'(a_sh);
    end

    always_comb begin
        creq.start = 1'b0;
        creq.x = den;
        creq.y = num;
        if (state_reg == S_YAW) begin
            creq.start = ((tt < 0) ? -tt : tt) * 2 < d2;
        end else if (state_reg == S_DIST) begin
            creq.start = 1'b1;
            creq.x = dxs;
            creq.y = dys;
        end
    end

    // A send goal beat is accepted as a goal only when no goal is pending.
    logic goal_ok;
    assign goal_ok = (s_tuser == OP_GOAL) && (status_reg != ST_PENDING);

    assign s_tready = (state_reg == S_IDLE) && !m_tvalid;
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= 31'd6554; ling_reg <= 16'd256; linl_reg <= 31'd32768;
            angg_reg <= 16'd256; angl_reg <= 31'd65536;
            gx_reg <= '0; gy_reg <= '0;
            present_reg <= 1'b0; status_reg <= ST_IDLE;
            state_reg <= S_IDLE; m_tvalid <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_TOL:  tol_reg  <= cfg_data;
                    CFG_LING: ling_reg <= cfg_data[15:0];
                    CFG_LINL: linl_reg <= cfg_data;
                    CFG_ANGG: angg_reg <= cfg_data[15:0];
                    CFG_ANGL: angl_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_tvalid && s_tready) begin
                    px_reg <= s_tdata[31:0];   py_reg <= s_tdata[63:32];
                    qx_reg <= s_tdata[79:64];  qy_reg <= s_tdata[95:80];
                    qz_reg <= s_tdata[111:96]; qw_reg <= s_tdata[127:112];
                    out_reg <= {7'd0, goal_ok, 64'd0};
                    state_reg <= S_OUT;
                    unique case (s_tuser)
                        OP_GOAL: if (status_reg != ST_PENDING) begin
                            gx_reg <= s_tdata[31:0]; gy_reg <= s_tdata[63:32];
                            present_reg <= 1'b1; status_reg <= ST_PENDING;
                        end
                        OP_CANCEL: begin
                            present_reg <= 1'b0; status_reg <= ST_CANCELED;
                        end
                        OP_RESET: begin
                            present_reg <= 1'b0; status_reg <= ST_IDLE;
                        end
                        default: if (present_reg && status_reg == ST_PENDING)
                            state_reg <= S_YAW;
                    endcase
                end
                S_YAW: begin
                    yaw_reg   <= '0;
                    state_reg <= creq.start ? S_YAWW : S_DIST;
                end
                S_YAWW: if (crsp.done) begin
                    yaw_reg   <= crsp.angle;
                    state_reg <= S_DIST;
                end
                S_DIST: state_reg <= S_DISTW;
                S_DISTW: if (crsp.done) begin
                    dist_reg  <= crsp.mag;
                    err_reg   <= ew;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    lprod_reg <= 51'(ling_reg) * 51'(dist_reg) + 51'd128;
                    aprod_reg <= 36'(signed'({2'b0, angg_reg})) * 36'(err_reg) + 36'sd16;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    // Reached: zero command with the reached flag; otherwise both speeds.
                    if (dist_reg <= 34'(tol_reg)) begin
                        present_reg <= 1'b0; status_reg <= ST_SUCCEEDED;
                        out_reg[65:0] <= {2'b10, 63'd0, 1'b1};
                    end else begin
                        out_reg[65:0] <= {2'b00, ang_c, lin_c, 1'b1};
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    out_reg[67:66] <= status_reg;
                    m_tvalid  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/gtg_checker.sv */
// Port-level checks of the go-to-goal pose controller, bound to the top level.
module gtg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("stall");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("take while result waits");
    a_one_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[64] && m_tdata[0])) else $error("flags clash");
    a_reach_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[65] |-> m_tdata[63:1] == 63'd0 && m_tdata[67:66] == 2'd2)
        else $error("reach result");
endmodule

bind go_to_goal_pose_controller_unit gtg_checker u_gtg_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
